[sv/sdtq_pkg.sv]
// Package: widths, constants and shared types of the sorted deadline timer queue.
package sdtq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int FREQ_W      = 32;
	localparam int SECS_W      = 16;
	localparam int TAG_W       = 8;
	localparam int TIME_W      = 64;
	localparam int SPAN_W      = FREQ_W + SECS_W;
	localparam int PEND_W      = 5;

	localparam int S_DATA_W = ((SECS_W + TAG_W + 7) / 8) * 8;
	localparam int S_USER_W = 1;
	localparam int M_BITS   = TAG_W + TIME_W + PEND_W;
	localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;
	localparam int M_USER_W = 2;

	localparam logic [FREQ_W-1:0] FREQ_RESET   = FREQ_W'(62500000);
	localparam logic [SECS_W-1:0] IDLE_SECONDS = SECS_W'(10000);

	// request kinds carried on s_tuser
	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] deadline;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   new_entry;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_APPLY
	} state_t;

endpackage

[sv/sdtq_cell.sv]
// One slot of the sorted queue: keeps, shifts or takes the new entry.
module sdtq_cell (
	input  logic                clk,
	input  sdtq_pkg::cell_ctrl_t ctrl,
	input  sdtq_pkg::entry_t    prev_entry,
	input  logic                prev_le,
	input  sdtq_pkg::entry_t    next_entry,
	input  logic                occupied,
	output sdtq_pkg::entry_t    entry,
	output logic                le
);
	import sdtq_pkg::*;

	entry_t entry_q;

	// Sorted order makes le a prefix: the first slot with le low takes the new entry.
	assign le    = occupied && (entry_q.deadline <= ctrl.new_entry.deadline);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_INSERT: begin
				if (!le) begin
					entry_q <= prev_le ? ctrl.new_entry : prev_entry;
				end
			end
			OP_POP: entry_q <= next_entry;
			default: entry_q <= entry_q;
		endcase
	end

endmodule

[sv/sorted_deadline_timer_queue.sv]
// Top level: tick counter, deadline arithmetic, sorted cell chain and result register.
// Sequence: multiply at accept, deadline add and compare, then queue update with result
//   register load.
// Requests: a new request is taken only in idle, once the sequencer has stepped the
//   single multiplier and 64-bit adder and the chain has updated; a stalled result holds it.
// Reset (arst_n low): counter and occupancy clear, compare goes to all ones,
//   tick_frequency returns to 62500000; slot contents stay unknown and are never read.
module sorted_deadline_timer_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sdtq_pkg::FREQ_W-1:0]    cfg_wdata,   // tick_frequency
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sdtq_pkg::S_DATA_W-1:0]  s_tdata,     // timeout_seconds, event_tag
	input  logic                           s_tuser,     // req_type
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sdtq_pkg::M_DATA_W-1:0]  m_tdata,     // fired_tag, compare_value,
	                                                    // pending_count, zero pad
	output logic [sdtq_pkg::M_USER_W-1:0]  m_tuser      // fired, add_rejected
);
	import sdtq_pkg::*;

	state_t state_q, state_d;

	logic [FREQ_W-1:0] freq_q;
	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] cmp_q;
	logic [CNT_W-1:0]  count_q;

	// item registers held across the sequence
	logic              req_q;
	logic [TAG_W-1:0]  tag_q;
	logic [SPAN_W-1:0] span_q;
	logic [TIME_W-1:0] dl_q;
	logic              hit_q;

	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic [M_USER_W-1:0] m_tuser_q;

	logic              accept;
	logic              out_free;
	logic              apply;
	logic [SECS_W-1:0] secs_sel;
	logic [SPAN_W-1:0] span_d;
	logic [TIME_W:0]   sum;

	// chain signals
	entry_t     cell_entry [QUEUE_DEPTH];
	logic       cell_le    [QUEUE_DEPTH];
	cell_ctrl_t ctrl;

	// results of the update step
	logic              full;
	logic              fired_d;
	logic [TAG_W-1:0]  ftag_d;
	logic              rej_d;
	logic [CNT_W-1:0]  count_d;
	logic [TIME_W-1:0] cmp_d;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign apply    = (state_q == ST_APPLY) && out_free;

	// A tick takes the idle span, which reloads compare once the queue drains; an add uses its own timeout.
	assign secs_sel = (s_tuser == REQ_TICK) ? IDLE_SECONDS : s_tdata[SECS_W-1:0];
	assign span_d   = SPAN_W'(freq_q) * SPAN_W'(secs_sel);
	assign sum      = {1'b0, time_q} + (TIME_W + 1)'(span_q);

	// Sequencer: idle -> deadline add -> queue update (waits for a free result register).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_SUM;
			ST_SUM:   state_d = ST_APPLY;
			ST_APPLY: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Register and counter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q  <= FREQ_RESET;
			time_q  <= '0;
			cmp_q   <= '1;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				freq_q <= cfg_wdata;
			end
			if (accept && (s_tuser == REQ_TICK)) begin
				time_q <= time_q + TIME_W'(1);
			end
			if (apply) begin
				cmp_q   <= cmp_d;
				count_q <= count_d;
			end
		end
	end

	// Item payload: multiply at accept, saturating add and expiry compare next.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= s_tuser;
			tag_q  <= s_tdata[SECS_W +: TAG_W];
			span_q <= span_d;
		end
		if (state_q == ST_SUM) begin
			dl_q  <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
			hit_q <= (time_q >= cmp_q);
		end
	end

	// Decide the queue operation and the values after it.
	always_comb begin
		full    = (count_q == CNT_W'(QUEUE_DEPTH));
		fired_d = 1'b0;
		ftag_d  = '0;
		rej_d   = 1'b0;
		count_d = count_q;
		cmp_d   = cmp_q;
		ctrl.op = OP_HOLD;
		ctrl.new_entry.deadline = dl_q;
		ctrl.new_entry.tag      = tag_q;
		if (req_q == REQ_ADD) begin
			if (full) begin
				rej_d = 1'b1;
			end else begin
				ctrl.op = OP_INSERT;
				count_d = count_q + CNT_W'(1);
				// new head is the old head unless the new deadline sorts before it
				cmp_d   = cell_le[0] ? cell_entry[0].deadline : dl_q;
			end
		end else if (hit_q) begin
			if (count_q != '0) begin
				ctrl.op = OP_POP;
				fired_d = 1'b1;
				ftag_d  = cell_entry[0].tag;
				count_d = count_q - CNT_W'(1);
			end
			// fall back to the idle deadline once the queue drains
			cmp_d = (count_q > CNT_W'(1)) ? cell_entry[1].deadline : dl_q;
		end
		if (!apply) begin
			ctrl.op = OP_HOLD;
		end
	end

	// Cell chain: slot 0 holds the earliest deadline.
	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_l;

		if (k == 0) begin : g_head
			assign prev_e = cell_entry[0];
			assign prev_l = 1'b1;
		end else begin : g_body
			assign prev_e = cell_entry[k-1];
			assign prev_l = cell_le[k-1];
		end

		if (k == QUEUE_DEPTH - 1) begin : g_tail
			assign next_e = cell_entry[k];
		end else begin : g_inner
			assign next_e = cell_entry[k+1];
		end

		sdtq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.prev_entry(prev_e),
			.prev_le   (prev_l),
			.next_entry(next_e),
			.occupied  (CNT_W'(k) < count_q),
			.entry     (cell_entry[k]),
			.le        (cell_le[k])
		);
	end

	// Result register: parts the update from the downstream handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (apply) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			m_tdata_q <= M_DATA_W'({PEND_W'(count_d), cmp_d, ftag_d});
			m_tuser_q <= {rej_d, fired_d};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[sv/sdtq_checker.sv]
// Checker: port-level properties of the timer queue, bound to the top level.
module sdtq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [sdtq_pkg::M_DATA_W-1:0]  m_tdata,
	input logic [sdtq_pkg::M_USER_W-1:0]  m_tuser
);
	import sdtq_pkg::*;

	localparam int PC_LO = TAG_W + TIME_W;

	// no tag unless an event fired
	a_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[TAG_W-1:0] == '0)
		else $error("fired_tag nonzero without fire");

	// a rejected add never pops
	a_rej_fire: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0])
		else $error("reject and fire together");

	// reject only when the queue is full
	a_rej_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[PC_LO +: PEND_W] == PEND_W'(QUEUE_DEPTH))
		else $error("reject with queue not full");

	// a pop leaves room in the queue
	a_fire_room: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[PC_LO +: PEND_W] != PEND_W'(QUEUE_DEPTH))
		else $error("fire with queue still full");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (.*);

[dv/tb_sorted_deadline_timer_queue.sv]
// Testbench: stream-driven regression of the sorted deadline timer queue against a predictor.
module tb_sorted_deadline_timer_queue;
	import sdtq_pkg::*;

	localparam int STALL_LIMIT   = 5000;   // cycles with no transaction on either side
	localparam int DRAIN_CYCLES  = 6;      // settling margin after the last expected result
	localparam int PHASE_ITEMS   = 225;
	localparam int NUM_PHASES    = 8;

	// One result transaction, split into its fields
	typedef struct {
		logic              fired;
		logic [TAG_W-1:0]  fired_tag;
		logic [TIME_W-1:0] compare_value;
		logic [PEND_W-1:0] pending_count;
		logic              add_rejected;
	} timer_result_t;

	// Scoreboard: keeps its own copy of counter, compare and sorted queue, predicts the
	// result of each accepted request and checks results in order.
	class timer_scoreboard;
		logic [FREQ_W-1:0] tick_freq;
		logic [TIME_W-1:0] now_ticks;
		logic [TIME_W-1:0] compare_reg;
		entry_t            pending_events[$];
		timer_result_t     expected_results[$];
		int                errors;

		function new();
			tick_freq   = FREQ_RESET;
			now_ticks   = '0;
			compare_reg = '1;
			errors      = 0;
		endfunction

		function void set_frequency(logic [FREQ_W-1:0] f);
			tick_freq = f;
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction

		// now + freq * seconds, saturating at the top of the 64-bit range
		function logic [TIME_W-1:0] deadline_after(logic [SECS_W-1:0] secs);
			logic [TIME_W-1:0] span;
			logic [TIME_W:0]   sum;
			span = TIME_W'(tick_freq) * TIME_W'(secs);
			sum  = {1'b0, now_ticks} + {1'b0, span};
			return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
		endfunction

		function void note_request(logic req, logic [SECS_W-1:0] secs, logic [TAG_W-1:0] tag);
			timer_result_t     r;
			entry_t            e;
			logic [TIME_W-1:0] dl;
			int                pos;
			r = '{default: '0};
			if (req == REQ_ADD) begin
				if (pending_events.size() >= QUEUE_DEPTH) begin
					r.add_rejected = 1'b1;
				end else begin
					dl  = deadline_after(secs);
					pos = 0;
					// equal deadlines keep arrival order: insert behind them
					while (pos < pending_events.size() && pending_events[pos].deadline <= dl)
						pos++;
					e.deadline = dl;
					e.tag      = tag;
					pending_events.insert(pos, e);
					compare_reg = pending_events[0].deadline;
				end
			end else begin
				now_ticks = now_ticks + 1;
				if (now_ticks >= compare_reg) begin
					if (pending_events.size() > 0) begin
						r.fired     = 1'b1;
						r.fired_tag = pending_events[0].tag;
						void'(pending_events.pop_front());
					end
					if (pending_events.size() > 0)
						compare_reg = pending_events[0].deadline;
					else
						compare_reg = deadline_after(IDLE_SECONDS);
				end
			end
			r.compare_value = compare_reg;
			r.pending_count = PEND_W'(pending_events.size());
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [M_DATA_W-1:0] data, logic [M_USER_W-1:0] user);
			timer_result_t got;
			timer_result_t exp_r;
			got.fired_tag     = data[TAG_W-1:0];
			got.compare_value = data[TAG_W +: TIME_W];
			got.pending_count = data[TAG_W+TIME_W +: PEND_W];
			got.fired         = user[0];
			got.add_rejected  = user[1];
			if (expected_results.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
				return;
			end
			exp_r = expected_results.pop_front();
			if (got.fired !== exp_r.fired) begin
				$error("fired: expected %0d, actual %0d", exp_r.fired, got.fired);
				errors++;
			end
			if (got.fired_tag !== exp_r.fired_tag) begin
				$error("fired_tag: expected %0d, actual %0d", exp_r.fired_tag, got.fired_tag);
				errors++;
			end
			if (got.compare_value !== exp_r.compare_value) begin
				$error("compare_value: expected %0d, actual %0d",
					exp_r.compare_value, got.compare_value);
				errors++;
			end
			if (got.pending_count !== exp_r.pending_count) begin
				$error("pending_count: expected %0d, actual %0d",
					exp_r.pending_count, got.pending_count);
				errors++;
			end
			if (got.add_rejected !== exp_r.add_rejected) begin
				$error("add_rejected: expected %0d, actual %0d",
					exp_r.add_rejected, got.add_rejected);
				errors++;
			end
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [FREQ_W-1:0]   cfg_wdata = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata   = '0;   // timeout_seconds, event_tag
	logic                s_tuser   = 1'b0; // req_type
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;          // fired_tag, compare_value, pending_count, pad
	logic [M_USER_W-1:0] m_tuser;          // fired, add_rejected

	timer_scoreboard sb = new();
	bit              calm = 1'b0;  // set to suppress idling on both sides

	sorted_deadline_timer_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Receiver: stall about 11 percent of the time unless calm
	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 11);
	end

	// Check every result transaction against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// Watchdog: end the run when no transaction moves for too long
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("sorted_deadline_timer_queue regression: fail");
		$finish;
	end

	// Present one request and hold it until accepted. Valid stays high afterwards so
	// back-to-back requests go out with no gap; an idle cycle drops it.
	task automatic send_request(input logic req, input logic [SECS_W-1:0] secs,
			input logic [TAG_W-1:0] tag);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 11) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {tag, secs};
		do @(posedge clk); while (!s_tready);
		sb.note_request(req, secs, tag);
	endtask

	task automatic release_requests();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Write tick_frequency once the block has drained and settled
	task automatic set_tick_frequency(input logic [FREQ_W-1:0] f);
		release_requests();
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= f;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_frequency(f);
	endtask

	// Random request mix; seconds are shaped by the frequency so that most events
	// actually expire within the ticks of a phase.
	task automatic random_phase(input logic [FREQ_W-1:0] f, input int n_items);
		int                done_items;
		int                k;
		logic [SECS_W-1:0] secs;
		done_items = 0;
		while (done_items < n_items) begin
			if ($urandom_range(0, 99) < 4) begin
				// burst of adds: push the queue to full and past it
				for (k = 0; k < QUEUE_DEPTH + 2; k++) begin
					secs = (f == 0) ? SECS_W'($urandom_range(0, 65535))
						: SECS_W'($urandom_range(0, 6));
					send_request(REQ_ADD, secs, TAG_W'($urandom_range(0, 255)));
				end
				done_items += QUEUE_DEPTH + 2;
			end else if ($urandom_range(0, 99) < 55) begin
				send_request(REQ_TICK, SECS_W'($urandom_range(0, 65535)),
					TAG_W'($urandom_range(0, 255)));
				done_items++;
			end else begin
				if (f == 0)
					secs = SECS_W'($urandom_range(0, 65535));
				else if (f <= 8)
					secs = SECS_W'($urandom_range(0, 12));
				else if ($urandom_range(0, 19) == 0)
					secs = SECS_W'($urandom_range(1, 65535));
				else
					secs = '0;
				send_request(REQ_ADD, secs, TAG_W'($urandom_range(0, 255)));
				done_items++;
			end
		end
	endtask

	initial begin
		logic [FREQ_W-1:0] phase_freq [NUM_PHASES];
		int                i;
		phase_freq = '{32'd0, 32'd1, 32'd5, 32'd2, 32'd62500000, 32'd0, 32'd1, 32'hFFFF_FFFF};

		// hold reset, then release it away from the clock edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset frequency: tick against the all-ones compare, an expired add,
		// the widest add, and two equal deadlines that must pop in arrival order.
		send_request(REQ_TICK, '0, '0);
		send_request(REQ_ADD, '0, 8'h00);
		send_request(REQ_ADD, 16'hFFFF, 8'hFF);
		send_request(REQ_TICK, '0, '0);
		send_request(REQ_ADD, '0, 8'hA5);
		send_request(REQ_ADD, '0, 8'h5A);
		send_request(REQ_TICK, '0, '0);
		send_request(REQ_TICK, '0, '0);
		send_request(REQ_TICK, 16'hFFFF, 8'hFF);

		// Directed, zero frequency: every deadline equals now; overfill the queue
		set_tick_frequency('0);
		for (i = 0; i < QUEUE_DEPTH; i++)
			send_request(REQ_ADD, SECS_W'(i * 4369), TAG_W'(i * 17));

		// Random phases across frequencies, extremes included; one phase runs calm
		for (i = 0; i < NUM_PHASES; i++) begin
			if (i != 0)
				set_tick_frequency(phase_freq[i]);
			calm = (i == 3);
			random_phase(phase_freq[i], PHASE_ITEMS);
		end
		calm = 1'b0;

		// drain: wait for every expected result, then a settling margin
		release_requests();
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("sorted_deadline_timer_queue regression: pass");
		else
			$display("sorted_deadline_timer_queue regression: fail");
		$finish;
	end

endmodule

[filelist.f]
sv/sdtq_pkg.sv
sv/sdtq_cell.sv
sv/sorted_deadline_timer_queue.sv
sv/sdtq_checker.sv
dv/tb_sorted_deadline_timer_queue.sv
